### rtl/syr_pkg.sv
// ============================================================================
// syr_pkg: shared definitions for the token reorder block
// Field widths and the codes carried by input and result words.
// ============================================================================
`default_nettype none

package syr_pkg;

    localparam int TOKEN_KIND_W  = 3;
    localparam int TOKEN_VALUE_W = 32;
    localparam int PRIO_W        = 4;
    localparam int OUT_KIND_W    = 2;
    localparam int ERR_W         = 2;

    typedef logic [TOKEN_KIND_W-1:0] token_kind_t;
    typedef logic [OUT_KIND_W-1:0]   out_kind_t;
    typedef logic [ERR_W-1:0]        err_code_t;
    typedef logic [PRIO_W-1:0]       prio_t;

    // Input token kinds; codes above TK_END are ignored.
    localparam token_kind_t TK_OPERAND  = 3'd0;
    localparam token_kind_t TK_LEFT     = 3'd1;
    localparam token_kind_t TK_RIGHT    = 3'd2;
    localparam token_kind_t TK_OPERATOR = 3'd3;
    localparam token_kind_t TK_END      = 3'd4;

    // Result kinds.
    localparam out_kind_t OK_OPERAND  = 2'd0;
    localparam out_kind_t OK_OPERATOR = 2'd1;
    localparam out_kind_t OK_END      = 2'd2;
    localparam out_kind_t OK_ERROR    = 2'd3;

    // Error codes.
    localparam err_code_t ERR_NONE      = 2'd0;
    localparam err_code_t ERR_TOO_LONG  = 2'd1;
    localparam err_code_t ERR_UNMATCHED = 2'd2;

endpackage

`default_nettype wire

### rtl/syr_token_if.sv
// ============================================================================
// syr_token_if: input token channel
// Valid/ready channel carrying one infix token word.
// ============================================================================
`default_nettype none

interface syr_token_if import syr_pkg::*; ();

    logic        valid;
    logic        ready;
    token_kind_t token_kind;
    logic [TOKEN_VALUE_W-1:0] token_value;
    prio_t       token_priority;

    modport source (output valid, output token_kind, output token_value,
                    output token_priority, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input token_priority, output ready);

endinterface

`default_nettype wire

### rtl/syr_result_if.sv
// ============================================================================
// syr_result_if: result channel
// Valid/ready channel carrying one reordered token or status word.
// ============================================================================
`default_nettype none

interface syr_result_if import syr_pkg::*; ();

    logic      valid;
    logic      ready;
    out_kind_t out_kind;
    logic [TOKEN_VALUE_W-1:0] out_value;
    prio_t     out_priority;
    err_code_t error_code;
    logic      last_of_run;

    modport source (output valid, output out_kind, output out_value,
                    output out_priority, output error_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_kind, input out_value,
                    input out_priority, input error_code, input last_of_run,
                    output ready);

endinterface

`default_nettype wire

### rtl/shunting_yard_token_reorder.sv
// ============================================================================
// shunting_yard_token_reorder: infix to reverse Polish token reordering
// Operator stack in a synchronous memory, one stack entry handled per cycle unless the result stalls.
// ============================================================================
// Tokens arrive in infix order on the token channel and leave in reverse Polish
// order on the result channel. Operands pass straight through; operators and
// left brackets are kept on a stack held in a single synchronous memory of
// STACK_DEPTH entries, whose top entry is always waiting in the registered read
// port. An operand or a left bracket is handled in the decode state. An
// operator, a right bracket or an end marker goes on to the popping state,
// which pops its operators one by one, as the stack memory yields one entry
// per cycle while the result channel is not stalled. Results sit in an
// output register, so a new token is taken while the last word still waits.
// last_of_run marks the final word caused by a token. Errors (an expression of
// more than STACK_DEPTH tokens, or an unmatched bracket) give one error word;
// after a too-long or unmatched right bracket error every token is dropped up
// to and including the next end marker. Stack entries are never cleared, only
// the depth is reset, so no clearing pass is needed after reset.
`default_nettype none

module shunting_yard_token_reorder
    import syr_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    syr_token_if.sink   token,
    syr_result_if.source result
);

    // Stored payload width: the port carries at most TOKEN_VALUE_W bits.
    localparam int SW = (VALUE_WIDTH < TOKEN_VALUE_W) ? VALUE_WIDTH : TOKEN_VALUE_W;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_POP    = 2'd2;

    typedef struct packed {
        logic          bracket;
        prio_t         prio;
        logic [SW-1:0] value;
    } entry_t;

    // Control state.
    logic [1:0]    state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] count_reg, count_next;
    logic          discard_reg, discard_next;
    logic          hold_valid_reg, hold_valid_next;
    logic          out_valid_reg;

    // Payload state.
    token_kind_t   tok_kind_reg;
    logic [SW-1:0] tok_value_reg;
    prio_t         tok_prio_reg;
    entry_t        hold_reg, hold_next;
    entry_t        rd_data_reg;
    out_kind_t     out_kind_reg;
    logic [TOKEN_VALUE_W-1:0] out_value_reg;
    prio_t         out_prio_reg;
    err_code_t     out_err_reg;
    logic          out_last_reg;

    // Stack memory.
    entry_t        stack_mem [STACK_DEPTH];
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    entry_t        mem_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_ptr;

    // Output load.
    logic          out_load;
    out_kind_t     ld_kind;
    logic [TOKEN_VALUE_W-1:0] ld_value;
    prio_t         ld_prio;
    err_code_t     ld_err;
    logic          ld_last;

    // Per-cycle decisions of the popping loop.
    logic          out_free;
    logic          top_empty;
    logic          step_pop;
    logic          step_res;
    out_kind_t     res_kind;
    err_code_t     res_err;
    logic          do_finish;

    assign token.ready  = (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || result.ready;
    assign top_empty    = (depth_reg == '0);

    assign result.valid        = out_valid_reg;
    assign result.out_kind     = out_kind_reg;
    assign result.out_value    = out_value_reg;
    assign result.out_priority = out_prio_reg;
    assign result.error_code   = out_err_reg;
    assign result.last_of_run  = out_last_reg;

    // Classify the current stack top against the token being worked on.
    always_comb
    begin
        step_pop = 1'b0;
        step_res = 1'b0;
        res_kind = OK_END;
        res_err  = ERR_NONE;
        case (tok_kind_reg)
            TK_OPERATOR:
            begin
                step_pop = !top_empty && !rd_data_reg.bracket &&
                           (tok_prio_reg <= rd_data_reg.prio);
            end
            TK_RIGHT:
            begin
                if (top_empty)
                begin
                    step_res = 1'b1;
                    res_kind = OK_ERROR;
                    res_err  = ERR_UNMATCHED;
                end
                else
                begin
                    step_pop = !rd_data_reg.bracket;
                end
            end
            default:
            begin
                // End marker.
                if (top_empty)
                begin
                    step_res = 1'b1;
                end
                else if (rd_data_reg.bracket)
                begin
                    step_res = 1'b1;
                    res_kind = OK_ERROR;
                    res_err  = ERR_UNMATCHED;
                end
                else
                begin
                    step_pop = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        discard_next    = discard_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        mem_we          = 1'b0;
        wr_addr         = depth_reg[AW-1:0];
        mem_wdata       = '{bracket: 1'b0, prio: tok_prio_reg, value: tok_value_reg};
        out_load        = 1'b0;
        ld_kind         = OK_OPERAND;
        ld_value        = '0;
        ld_prio         = '0;
        ld_err          = ERR_NONE;
        ld_last         = 1'b0;
        do_finish       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (token.valid)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                case (tok_kind_reg)
                    TK_END:
                    begin
                        if (discard_reg)
                        begin
                            discard_next = 1'b0;
                            depth_next   = '0;
                            count_next   = '0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_POP;
                        end
                    end
                    TK_OPERAND, TK_LEFT, TK_RIGHT, TK_OPERATOR:
                    begin
                        if (discard_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (count_reg >= DW'(STACK_DEPTH))
                        begin
                            if (out_free)
                            begin
                                out_load     = 1'b1;
                                ld_kind      = OK_ERROR;
                                ld_err       = ERR_TOO_LONG;
                                ld_last      = 1'b1;
                                discard_next = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end
                        else if (tok_kind_reg == TK_OPERAND)
                        begin
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                ld_kind    = OK_OPERAND;
                                ld_value   = TOKEN_VALUE_W'(tok_value_reg);
                                ld_last    = 1'b1;
                                count_next = count_reg + 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else if (tok_kind_reg == TK_LEFT)
                        begin
                            count_next = count_reg + 1'b1;
                            if (depth_reg < DW'(STACK_DEPTH))
                            begin
                                mem_we            = 1'b1;
                                mem_wdata.bracket = 1'b1;
                                mem_wdata.prio    = '0;
                                depth_next        = depth_reg + 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            state_next = ST_POP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_POP:
            begin
                // A popped operator waits in the hold register until the
                // next step shows whether it is the last word of the token.
                if (hold_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        ld_kind  = OK_OPERATOR;
                        ld_value = TOKEN_VALUE_W'(hold_reg.value);
                        ld_prio  = hold_reg.prio;
                        if (step_pop)
                        begin
                            hold_next  = rd_data_reg;
                            depth_next = depth_reg - 1'b1;
                        end
                        else if (step_res)
                        begin
                            hold_valid_next = 1'b0;
                        end
                        else
                        begin
                            ld_last         = 1'b1;
                            hold_valid_next = 1'b0;
                            do_finish       = 1'b1;
                        end
                    end
                end
                else if (step_pop)
                begin
                    hold_next       = rd_data_reg;
                    hold_valid_next = 1'b1;
                    depth_next      = depth_reg - 1'b1;
                end
                else if (step_res)
                begin
                    if (out_free)
                    begin
                        out_load  = 1'b1;
                        ld_kind   = res_kind;
                        ld_err    = res_err;
                        ld_last   = 1'b1;
                        do_finish = 1'b1;
                    end
                end
                else
                begin
                    do_finish = 1'b1;
                end

                if (do_finish)
                begin
                    state_next = ST_IDLE;
                    case (tok_kind_reg)
                        TK_OPERATOR:
                        begin
                            if (depth_reg < DW'(STACK_DEPTH))
                            begin
                                mem_we     = 1'b1;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        TK_RIGHT:
                        begin
                            if (step_res)
                            begin
                                discard_next = 1'b1;
                            end
                            else
                            begin
                                // Drop the matching left bracket.
                                depth_next = depth_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            depth_next = '0;
                            count_next = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The read port always fetches the entry that will be on top next cycle.
    assign rd_ptr  = depth_next - 1'b1;
    assign rd_addr = rd_ptr[AW-1:0];
    assign rd_en   = (depth_next != '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= mem_wdata;
        end
        if (rd_en)
        begin
            // A push makes the new entry the top: forward it past the memory.
            if (mem_we && (wr_addr == rd_addr))
            begin
                rd_data_reg <= mem_wdata;
            end
            else
            begin
                rd_data_reg <= stack_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            count_reg      <= '0;
            discard_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
            discard_reg    <= discard_next;
            hold_valid_reg <= hold_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (token.valid && token.ready)
        begin
            tok_kind_reg  <= token.token_kind;
            tok_value_reg <= token.token_value[SW-1:0];
            tok_prio_reg  <= token.token_priority;
        end
        hold_reg <= hold_next;
        if (out_load)
        begin
            out_kind_reg  <= ld_kind;
            out_value_reg <= ld_value;
            out_prio_reg  <= ld_prio;
            out_err_reg   <= ld_err;
            out_last_reg  <= ld_last;
        end
    end

    // The stack can never hold more entries than the counted tokens.
    a_depth_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg <= count_reg) && (count_reg <= DW'(STACK_DEPTH)))
        else $error("stack depth exceeds token count or limit");

    // A held operator exists only inside the popping loop.
    a_hold_only_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_POP) |-> !hold_valid_reg)
        else $error("held operator outside popping loop");

    // Every error word closes the run of its token.
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == OK_ERROR)) |-> out_last_reg)
        else $error("error word without last_of_run");

    // A freshly loaded word never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> result.ready)
        else $error("result word overwritten while stalled");

endmodule

`default_nettype wire

### tb/shunting_yard_token_reorder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// shunting_yard_token_reorder_tb: self-checking bench for the token reorder
// A table of directed tokens, then random well-formed, long, broken and noisy
// expressions, checked word by word against the table or the stack predictor.
// ============================================================================

module shunting_yard_token_reorder_tb;

    import syr_pkg::*;

    // Timing. The clock period is in nanoseconds.
    localparam int HALF_PERIOD   = 6;
    localparam int CLK_PERIOD    = 2 * HALF_PERIOD;
    localparam int LIMIT_CYCLES  = 250_000;
    // Quiet cycles after the last owed word, enough for an end marker that pops a
    // full stack, so that any word still in flight comes out.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_ITEMS  = 236;
    localparam int REPORT_LIMIT  = 10;

    // Must match the STACK_DEPTH parameter of the block (default used).
    localparam int STACK_SLOTS = 32;

    // Token kinds above the end marker; the block ignores them.
    localparam token_kind_t TK_RSVD_5 = 3'd5;
    localparam token_kind_t TK_RSVD_6 = 3'd6;
    localparam token_kind_t TK_RSVD_7 = 3'd7;

    typedef struct packed {
        token_kind_t              kind;
        logic [TOKEN_VALUE_W-1:0] value;
        prio_t                    prio;
    } token_t;

    typedef struct packed {
        out_kind_t                kind;
        logic [TOKEN_VALUE_W-1:0] value;
        prio_t                    prio;
        err_code_t                err;
        logic                     last;
    } word_t;

    typedef struct packed {
        logic                     bracket;
        prio_t                    prio;
        logic [TOKEN_VALUE_W-1:0] value;
    } stack_entry_t;

    // How a directed row is checked: by the predictor, as causing no word at
    // all, or against the single word typed into the table.
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} row_check_t;

    typedef struct packed {
        token_t     tok;
        row_check_t check;
        word_t      word;
    } row_t;

    localparam word_t NO_WORD = '0;
    localparam int    ROWS    = 24;

    // Directed table. The first half builds "a b op ( c op d ) op e" style
    // fragments with the extreme values and priorities, including an operator
    // that must stop at a stacked left bracket. Then a lone right bracket
    // (unmatched, the block starts dropping), dropped tokens, an undefined
    // kind, the end marker that closes the dropped expression, an unclosed
    // left bracket at the end, more undefined kinds and an empty expression.
    localparam row_t DIRECTED [ROWS] = '{
        '{'{TK_OPERAND,  32'h0000_0000, 4'h0}, CHK_ONE,
          '{OK_OPERAND, 32'h0000_0000, 4'h0, ERR_NONE, 1'b1}},
        '{'{TK_OPERAND,  32'hFFFF_FFFF, 4'hF}, CHK_ONE,
          '{OK_OPERAND, 32'hFFFF_FFFF, 4'h0, ERR_NONE, 1'b1}},
        '{'{TK_OPERATOR, 32'hFFFF_FFFF, 4'h0}, CHK_NONE, NO_WORD},
        '{'{TK_OPERAND,  32'h0000_0001, 4'h0}, CHK_ONE,
          '{OK_OPERAND, 32'h0000_0001, 4'h0, ERR_NONE, 1'b1}},
        '{'{TK_OPERATOR, 32'hA5A5_A5A5, 4'hF}, CHK_NONE, NO_WORD},
        '{'{TK_LEFT,     32'h1234_5678, 4'h0}, CHK_NONE, NO_WORD},
        '{'{TK_OPERAND,  32'h5A5A_5A5A, 4'h0}, CHK_ONE,
          '{OK_OPERAND, 32'h5A5A_5A5A, 4'h0, ERR_NONE, 1'b1}},
        '{'{TK_OPERATOR, 32'h0F0F_0F0F, 4'h0}, CHK_NONE, NO_WORD},
        '{'{TK_OPERAND,  32'h3C3C_3C3C, 4'h0}, CHK_ONE,
          '{OK_OPERAND, 32'h3C3C_3C3C, 4'h0, ERR_NONE, 1'b1}},
        '{'{TK_RIGHT,    32'h0000_0000, 4'h0}, CHK_PREDICT, NO_WORD},
        '{'{TK_OPERATOR, 32'h7777_7777, 4'hF}, CHK_PREDICT, NO_WORD},
        '{'{TK_OPERAND,  32'h0000_0080, 4'h0}, CHK_ONE,
          '{OK_OPERAND, 32'h0000_0080, 4'h0, ERR_NONE, 1'b1}},
        '{'{TK_END,      32'h0000_0000, 4'h0}, CHK_PREDICT, NO_WORD},
        '{'{TK_RIGHT,    32'h0000_0000, 4'h0}, CHK_ONE,
          '{OK_ERROR, 32'h0000_0000, 4'h0, ERR_UNMATCHED, 1'b1}},
        '{'{TK_OPERAND,  32'h0000_0011, 4'h0}, CHK_NONE, NO_WORD},
        '{'{TK_OPERATOR, 32'h0000_0022, 4'h5}, CHK_NONE, NO_WORD},
        '{'{TK_RSVD_5,   32'hFFFF_FFFF, 4'hF}, CHK_NONE, NO_WORD},
        '{'{TK_END,      32'h0000_0000, 4'h0}, CHK_NONE, NO_WORD},
        '{'{TK_LEFT,     32'h0000_0033, 4'h0}, CHK_NONE, NO_WORD},
        '{'{TK_OPERAND,  32'h0000_0044, 4'h0}, CHK_ONE,
          '{OK_OPERAND, 32'h0000_0044, 4'h0, ERR_NONE, 1'b1}},
        '{'{TK_END,      32'h0000_0000, 4'h0}, CHK_ONE,
          '{OK_ERROR, 32'h0000_0000, 4'h0, ERR_UNMATCHED, 1'b1}},
        '{'{TK_RSVD_6,   32'h0000_0000, 4'h0}, CHK_NONE, NO_WORD},
        '{'{TK_RSVD_7,   32'hFFFF_FFFF, 4'hF}, CHK_NONE, NO_WORD},
        '{'{TK_END,      32'h0000_0000, 4'h0}, CHK_ONE,
          '{OK_END, 32'h0000_0000, 4'h0, ERR_NONE, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;

    syr_token_if  token_ch ();
    syr_result_if result_ch ();

    shunting_yard_token_reorder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (token_ch),
        .result (result_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Predictor state: the operator stack, its fill level, the number of tokens
    // taken into the current expression and the dropping flag after an error.
    stack_entry_t opstack [STACK_SLOTS];
    int           stack_fill;
    int           expr_token_count;
    logic         dropping;

    word_t  step_words [$];      // words caused by the token just accepted
    word_t  expected_words [$];  // words still owed by the block, oldest first
    token_t expr_tokens [$];     // the random expression being built

    int   mismatch_count;
    int   random_items;
    logic send_idle;
    logic recv_idle;
    logic hold_wanted;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void add_word(input out_kind_t kind,
                                     input logic [TOKEN_VALUE_W-1:0] value,
                                     input prio_t prio, input err_code_t err);
        step_words.push_back('{kind, value, prio, err, 1'b0});
    endfunction

    // Works out every word that one accepted token causes, in order, and
    // updates the stack. The final word of the token carries last set.
    function automatic void reorder_token(input token_t t);
        stack_entry_t top;
        logic         bracket_hit;
        step_words.delete();
        if (t.kind == TK_END) begin
            if (dropping) begin
                // Closes a dropped expression silently.
                dropping         = 1'b0;
                stack_fill       = 0;
                expr_token_count = 0;
            end else begin
                bracket_hit = 1'b0;
                while (stack_fill > 0) begin
                    top = opstack[stack_fill - 1];
                    stack_fill--;
                    if (top.bracket) begin
                        bracket_hit = 1'b1;
                        break;
                    end
                    add_word(OK_OPERATOR, top.value, top.prio, ERR_NONE);
                end
                if (bracket_hit)
                    add_word(OK_ERROR, '0, '0, ERR_UNMATCHED);
                else
                    add_word(OK_END, '0, '0, ERR_NONE);
                stack_fill       = 0;
                expr_token_count = 0;
            end
        end else if (t.kind < TK_END && !dropping) begin
            if (expr_token_count >= STACK_SLOTS) begin
                add_word(OK_ERROR, '0, '0, ERR_TOO_LONG);
                dropping = 1'b1;
            end else begin
                expr_token_count++;
                case (t.kind)
                    TK_OPERAND:
                    begin
                        add_word(OK_OPERAND, t.value, '0, ERR_NONE);
                    end
                    TK_LEFT:
                    begin
                        if (stack_fill < STACK_SLOTS) begin
                            opstack[stack_fill] = '{1'b1, '0, t.value};
                            stack_fill++;
                        end
                    end
                    TK_RIGHT:
                    begin
                        bracket_hit = 1'b0;
                        while (stack_fill > 0) begin
                            top = opstack[stack_fill - 1];
                            stack_fill--;
                            if (top.bracket) begin
                                bracket_hit = 1'b1;
                                break;
                            end
                            add_word(OK_OPERATOR, top.value, top.prio, ERR_NONE);
                        end
                        if (!bracket_hit) begin
                            add_word(OK_ERROR, '0, '0, ERR_UNMATCHED);
                            dropping = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Operator: pop equal or higher priorities, never a
                        // bracket, then push.
                        while (stack_fill > 0) begin
                            top = opstack[stack_fill - 1];
                            if (top.bracket || t.prio > top.prio)
                                break;
                            stack_fill--;
                            add_word(OK_OPERATOR, top.value, top.prio, ERR_NONE);
                        end
                        if (stack_fill < STACK_SLOTS) begin
                            opstack[stack_fill] = '{1'b0, t.prio, t.value};
                            stack_fill++;
                        end
                    end
                endcase
            end
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Random expression building
    // ------------------------------------------------------------------------

    // Priorities are drawn mostly from a few values so that ties, which make
    // the block pop, are common.
    function automatic void add_token(input token_kind_t kind);
        prio_t prio;
        if ($urandom_range(0, 1) == 0)
            prio = ($urandom_range(0, 2) == 0) ? 4'd1 : 4'd7;
        else
            prio = prio_t'($urandom_range(0, 15));
        expr_tokens.push_back('{kind, TOKEN_VALUE_W'($urandom), prio});
    endfunction

    // Builds a bracket-balanced infix expression of at least target_len tokens
    // and closes it with an end marker.
    function automatic void build_expression(input int target_len, input int bracket_pct);
        int   open_n;
        logic want_operand;
        open_n       = 0;
        want_operand = 1'b1;
        while (expr_tokens.size() < target_len) begin
            if (want_operand) begin
                if ($urandom_range(0, 99) < bracket_pct) begin
                    add_token(TK_LEFT);
                    open_n++;
                end else begin
                    add_token(TK_OPERAND);
                    want_operand = 1'b0;
                end
            end else if (open_n > 0 && $urandom_range(0, 99) < 35) begin
                add_token(TK_RIGHT);
                open_n--;
            end else begin
                add_token(TK_OPERATOR);
                want_operand = 1'b1;
            end
        end
        if (want_operand)
            add_token(TK_OPERAND);
        repeat (open_n) add_token(TK_RIGHT);
        add_token(TK_END);
    endfunction

    // Strictly rising priorities, so nothing pops until the end marker flushes
    // the whole ladder at once.
    function automatic void build_ladder();
        add_token(TK_OPERAND);
        for (int p = 0; p < 15; p++) begin
            expr_tokens.push_back('{TK_OPERATOR, TOKEN_VALUE_W'($urandom), prio_t'(p)});
            add_token(TK_OPERAND);
        end
        add_token(TK_END);
    endfunction

    // ------------------------------------------------------------------------
    // Token side
    // ------------------------------------------------------------------------

    // Offers one token word, called and returning at a falling edge. The
    // expected words are queued at the accepting edge itself, before the block
    // can present any of them.
    task automatic offer_token(input token_t t, input row_check_t check, input word_t typed);
        int gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            token_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        token_ch.valid          <= 1'b1;
        token_ch.token_kind     <= t.kind;
        token_ch.token_value    <= t.value;
        token_ch.token_priority <= t.prio;
        do @(posedge clk); while (!token_ch.ready);
        // The predictor always runs so that its stack follows the block.
        reorder_token(t);
        if (check == CHK_PREDICT) begin
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        end else if (check == CHK_ONE) begin
            expected_words.push_back(typed);
        end
        if (t.kind <= TK_END)
            random_items++;
        @(negedge clk);
    endtask

    // Withdraws valid and waits until every owed word has come out, then lets
    // the block settle.
    task automatic drain_results();
        token_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : token_side
        int pick;
        int spot;
        int e;
        token_t tmp;
        rst_n                   = 1'b0;
        token_ch.valid          = 1'b0;
        token_ch.token_kind     = TK_OPERAND;
        token_ch.token_value    = '0;
        token_ch.token_priority = '0;
        hold_wanted             = 1'b0;
        send_idle               = 1'b1;
        mismatch_count          = 0;
        stack_fill              = 0;
        expr_token_count        = 0;
        dropping                = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < ROWS; i++)
            offer_token(DIRECTED[i].tok, DIRECTED[i].check, DIRECTED[i].word);
        // The sender waits here until every owed word has come out.
        drain_results();

        random_items = 0;
        e            = 0;
        while (random_items < RANDOM_ITEMS) begin
            expr_tokens.delete();
            // Runs of back-to-back tokens alternate with gappy stretches.
            send_idle = ($urandom_range(0, 3) != 0);
            // A long hold on the result side while tokens keep coming, so the
            // block backs up and stalls the token side.
            if (e == 2)
                hold_wanted = 1'b1;
            // A second full pause of the sender in the middle of the run.
            if (e == 12)
                drain_results();

            pick = (e == 0) ? 75 : $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 4) == 0)
                    build_expression($urandom_range(13, 31), 20);
                else
                    build_expression($urandom_range(2, 12), 20);
            end else if (pick < 72) begin
                if ($urandom_range(0, 1) == 0)
                    build_ladder();
                else
                    build_expression($urandom_range(15, 31), 60);
            end else if (pick < 80) begin
                // Beyond the size limit: too-long error, then dropping.
                build_expression($urandom_range(34, 44), 25);
            end else if (pick < 92) begin
                // A well-formed expression with one token spoilt.
                build_expression($urandom_range(3, 14), 25);
                spot = $urandom_range(0, expr_tokens.size() - 2);
                case ($urandom_range(0, 3))
                    0: expr_tokens.delete(spot);
                    1: expr_tokens.insert(spot, '{TK_LEFT, TOKEN_VALUE_W'($urandom), '0});
                    2: expr_tokens.insert(spot, '{TK_RIGHT, TOKEN_VALUE_W'($urandom), '0});
                    default:
                    begin
                        tmp      = expr_tokens[spot];
                        tmp.kind = token_kind_t'($urandom_range(0, 7));
                        expr_tokens[spot] = tmp;
                    end
                endcase
            end else begin
                // Noise: any kind, including the undefined ones.
                repeat ($urandom_range(1, 8))
                    add_token(token_kind_t'($urandom_range(0, 7)));
                if ($urandom_range(0, 1) == 0)
                    add_token(TK_END);
            end

            foreach (expr_tokens[i])
                offer_token(expr_tokens[i], CHK_PREDICT, NO_WORD);
            e++;
        end
        drain_results();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // In idle stretches ready may be lowered before each word, and it is lowered
    // once for a long hold when the token side asks for it.
    initial begin : result_side
        int stall;
        result_ch.ready = 1'b0;
        recv_idle       = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                recv_idle = ~recv_idle;
            stall = recv_idle ? $urandom_range(0, 3) : 0;
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                stall       = LONG_HOLD;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            @(negedge clk);
        end
    end

    // Each word taken is compared with the oldest owed word, field by field.
    always @(posedge clk) begin
        word_t got;
        word_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got = '{result_ch.out_kind, result_ch.out_value, result_ch.out_priority,
                    result_ch.error_code, result_ch.last_of_run};
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected word: kind %0d value %h prio %0d err %0d last %0d",
                             got.kind, got.value, got.prio, got.err, got.last);
            end else begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind || got.value !== want.value ||
                    got.prio !== want.prio || got.err !== want.err ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Mismatch: expected kind %0d value %h prio %0d err %0d last %0d",
                                 want.kind, want.value, want.prio, want.err, want.last);
                        $display("          got      kind %0d value %h prio %0d err %0d last %0d",
                                 got.kind, got.value, got.prio, got.err, got.last);
                    end
                end
            end
        end
    end

    // Watchdog for a hung handshake or missing words.
    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

endmodule
